>>> design/bta_pkg.sv
// ----------------------------------------------------------------------------
// bta_pkg
// Shared constants for the boundary-tag heap allocator: defaults, tag layout,
// operation and status codes.
// ----------------------------------------------------------------------------
package bta_pkg;

    localparam int HEAP_BYTES_DEF  = 65536;
    localparam int CHUNK_BYTES_DEF = 4096;

    localparam int TAG_W = 32;

    localparam logic [31:0] FIRST_BLOCK = 32'd16;
    localparam logic [31:0] MIN_BLOCK   = 32'd16;
    localparam logic [31:0] SIZE_MASK   = 32'hFFFF_FFF8;
    localparam logic [31:0] PROLOGUE    = 32'd9;
    localparam logic [31:0] EPILOGUE    = 32'd1;

    localparam logic [15:0] FREE_RESET_DEF = 16'd256;

    localparam logic [1:0] FUNC_ALLOC   = 2'd0;
    localparam logic [1:0] FUNC_RELEASE = 2'd1;
    localparam logic [1:0] FUNC_RESIZE  = 2'd2;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_NOMEM   = 2'd1;
    localparam logic [1:0] STAT_NULLREQ = 2'd2;

endpackage

>>> design/bta_tag_ram.sv
// ----------------------------------------------------------------------------
// bta_tag_ram
// Single-port tag store, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module bta_tag_ram #(
    parameter int WORDS = 16384,
    parameter int AW    = 14
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [AW-1:0]            addr,
    input  logic [bta_pkg::TAG_W-1:0] wdata,
    output logic [bta_pkg::TAG_W-1:0] rdata
);
    import bta_pkg::*;

    logic [TAG_W-1:0] mem [WORDS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

>>> design/boundary_tag_heap_allocator_core.sv
// ----------------------------------------------------------------------------
// boundary_tag_heap_allocator_core
// Next-fit allocator over an implicit boundary-tag block list held in one
// single-port tag memory; sequencer performs read-modify-write of tags.
// ----------------------------------------------------------------------------
// Allocate searches from the next-fit start and grows the heap when the search finds
//   no free block that fits; a resize with a nonzero pointer adds a release.
// Throughput: one transaction at a time; a request is taken only while the sequencer is idle.
// Reset: a clearing pass writes every tag word (prologue, first chunk if it fits,
//   epilogue laid down on the way); no request is taken until it ends.
// ----------------------------------------------------------------------------
module boundary_tag_heap_allocator_core
    import bta_pkg::*;
#(
    parameter int HEAP_BYTES  = HEAP_BYTES_DEF,
    parameter int CHUNK_BYTES = CHUNK_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] free_reset_count,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  func,
    input  logic [15:0] block_pointer,
    input  logic [15:0] request_size,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] result_pointer,
    output logic [1:0]  status,
    output logic [15:0] copy_bytes
);

    localparam int TAG_WORDS = HEAP_BYTES / 4;
    localparam int AW        = $clog2(TAG_WORDS);
    localparam int STEP_W    = $clog2(TAG_WORDS + 2);
    localparam int GROW_INIT = ((CHUNK_BYTES / 4) + ((CHUNK_BYTES / 4) % 2)) * 4;
    localparam bit INIT_FITS = (16 + GROW_INIT) <= HEAP_BYTES;
    localparam int INIT_FTR  = (16 + GROW_INIT - 8) / 4;
    localparam int INIT_EPI  = (16 + GROW_INIT - 4) / 4;

    localparam logic [31:0] GROW_INIT_W = 32'(GROW_INIT);
    localparam logic [31:0] CHUNK_W     = 32'(CHUNK_BYTES);
    localparam logic [32:0] HEAP_W      = 33'(HEAP_BYTES);
    localparam logic [31:0] HB_RESET    = INIT_FITS ? 32'(16 + GROW_INIT) : 32'd16;
    localparam logic [31:0] NSS_RESET   = INIT_FITS ? 32'd16 : 32'd8;
    localparam logic [STEP_W-1:0] STEP_MAX = STEP_W'(TAG_WORDS);

    localparam logic [4:0] ST_CLR     = 5'd0;
    localparam logic [4:0] ST_IDLE    = 5'd1;
    localparam logic [4:0] ST_SRCH    = 5'd2;
    localparam logic [4:0] ST_SRCH_D  = 5'd3;
    localparam logic [4:0] ST_GROW    = 5'd4;
    localparam logic [4:0] ST_GROW_W1 = 5'd5;
    localparam logic [4:0] ST_GROW_W2 = 5'd6;
    localparam logic [4:0] ST_MRG0    = 5'd7;
    localparam logic [4:0] ST_MRG1    = 5'd8;
    localparam logic [4:0] ST_MRG2    = 5'd9;
    localparam logic [4:0] ST_MRG3    = 5'd10;
    localparam logic [4:0] ST_MRG_W1  = 5'd11;
    localparam logic [4:0] ST_MRG_W2  = 5'd12;
    localparam logic [4:0] ST_PLACE   = 5'd13;
    localparam logic [4:0] ST_PLACE_D = 5'd14;
    localparam logic [4:0] ST_PL_W1   = 5'd15;
    localparam logic [4:0] ST_PL_W2   = 5'd16;
    localparam logic [4:0] ST_PL_W3   = 5'd17;
    localparam logic [4:0] ST_REL_CHK = 5'd18;
    localparam logic [4:0] ST_REL_D   = 5'd19;
    localparam logic [4:0] ST_REL_W   = 5'd20;
    localparam logic [4:0] ST_REL_FIN = 5'd21;
    localparam logic [4:0] ST_DONE    = 5'd22;

    function automatic logic [AW-1:0] tidx(input logic [31:0] off);
        tidx = off[AW+1:2];
    endfunction

    function automatic logic [31:0] init_word(input logic [AW-1:0] i);
        logic [31:0] w;
        begin
            w = '0;
            if (i == AW'(1) || i == AW'(2))
            begin
                w = PROLOGUE;
            end
            else if (i == AW'(3))
            begin
                w = INIT_FITS ? GROW_INIT_W : EPILOGUE;
            end
            else if (INIT_FITS && i == AW'(INIT_FTR))
            begin
                w = GROW_INIT_W;
            end
            else if (INIT_FITS && i == AW'(INIT_EPI))
            begin
                w = EPILOGUE;
            end
            init_word = w;
        end
    endfunction

    logic [4:0]        state_reg, state_next;
    logic [AW-1:0]     clr_reg, clr_next;
    logic [15:0]       ptr_reg, ptr_next;
    logic [15:0]       req_reg, req_next;
    logic [16:0]       asize_reg, asize_next;
    logic [31:0]       bp_reg, bp_next;
    logic [31:0]       sz_reg, sz_next;
    logic [31:0]       ptag_reg, ptag_next;
    logic [STEP_W-1:0] steps_reg, steps_next;
    logic [31:0]       hb_reg, hb_next;
    logic [31:0]       nss_reg, nss_next;
    logic [15:0]       cnt_reg, cnt_next;
    logic [15:0]       frc_reg, frc_next;
    logic [15:0]       res_reg, res_next;
    logic [1:0]        stat_reg, stat_next;
    logic [15:0]       copy_reg, copy_next;
    logic              rel_after_reg, rel_after_next;
    logic              copy_en_reg, copy_en_next;
    logic              to_place_reg, to_place_next;
    logic              split_reg, split_next;
    logic              ov_reg, ov_next;
    logic [15:0]       ores_reg, ores_next;
    logic [1:0]        ostat_reg, ostat_next;
    logic [15:0]       ocopy_reg, ocopy_next;

    logic              mem_we;
    logic [AW-1:0]     mem_addr;
    logic [31:0]       mem_wdata;
    logic [31:0]       mem_rdata;

    logic [31:0] rd_size;
    logic [31:0] asize_w;
    logic [31:0] ext;
    logic [31:0] gwords;
    logic [31:0] gsize;
    logic [31:0] psize;
    logic [31:0] old_len;
    logic [16:0] req_round;

    bta_tag_ram #(
        .WORDS (TAG_WORDS),
        .AW    (AW)
    ) u_tag_ram (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    assign cfg_ready      = 1'b1;
    assign in_ready       = (state_reg == ST_IDLE);
    assign out_valid      = ov_reg;
    assign result_pointer = ores_reg;
    assign status         = ostat_reg;
    assign copy_bytes     = ocopy_reg;

    assign rd_size   = mem_rdata & SIZE_MASK;
    assign asize_w   = {15'd0, asize_reg};
    assign ext       = (asize_w > CHUNK_W) ? asize_w : CHUNK_W;
    assign gwords    = (ext >> 2) + {31'd0, ext[2]};
    assign gsize     = gwords << 2;
    assign psize     = ptag_reg & SIZE_MASK;
    assign old_len   = rd_size - 32'd8;
    assign req_round = ({1'b0, request_size} + 17'd15) & 17'h1FFF8;

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        ptr_next       = ptr_reg;
        req_next       = req_reg;
        asize_next     = asize_reg;
        bp_next        = bp_reg;
        sz_next        = sz_reg;
        ptag_next      = ptag_reg;
        steps_next     = steps_reg;
        hb_next        = hb_reg;
        nss_next       = nss_reg;
        cnt_next       = cnt_reg;
        frc_next       = frc_reg;
        res_next       = res_reg;
        stat_next      = stat_reg;
        copy_next      = copy_reg;
        rel_after_next = rel_after_reg;
        copy_en_next   = copy_en_reg;
        to_place_next  = to_place_reg;
        split_next     = split_reg;
        ov_next        = ov_reg;
        ores_next      = ores_reg;
        ostat_next     = ostat_reg;
        ocopy_next     = ocopy_reg;
        mem_we         = 1'b0;
        mem_addr       = '0;
        mem_wdata      = '0;

        if (cfg_valid)
        begin
            frc_next = free_reset_count;
        end
        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            ST_CLR:
            begin
                mem_we    = 1'b1;
                mem_addr  = clr_reg;
                mem_wdata = init_word(clr_reg);
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == AW'(TAG_WORDS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    ptr_next       = block_pointer;
                    req_next       = request_size;
                    res_next       = '0;
                    copy_next      = '0;
                    stat_next      = STAT_OK;
                    rel_after_next = 1'b0;
                    copy_en_next   = 1'b0;
                    asize_next     = (request_size <= 16'd8) ? 17'd16 : req_round;
                    bp_next        = nss_reg;
                    steps_next     = '0;
                    case (func)
                        FUNC_ALLOC:
                        begin
                            if (request_size == 16'd0)
                            begin
                                stat_next  = STAT_NULLREQ;
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                state_next = ST_SRCH;
                            end
                        end
                        FUNC_RELEASE:
                        begin
                            state_next = ST_REL_CHK;
                        end
                        FUNC_RESIZE:
                        begin
                            if (request_size == 16'd0)
                            begin
                                stat_next  = STAT_NULLREQ;
                                state_next = ST_REL_CHK;
                            end
                            else
                            begin
                                rel_after_next = (block_pointer != 16'd0);
                                copy_en_next   = (block_pointer != 16'd0);
                                state_next     = ST_SRCH;
                            end
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_SRCH:
            begin
                if (steps_reg > STEP_MAX || bp_reg < 32'd4 || (bp_reg - 32'd4) >= hb_reg)
                begin
                    state_next = ST_GROW;
                end
                else
                begin
                    mem_addr   = tidx(bp_reg - 32'd4);
                    state_next = ST_SRCH_D;
                end
            end
            ST_SRCH_D:
            begin
                if (rd_size == 32'd0)
                begin
                    state_next = ST_GROW;
                end
                else if (!mem_rdata[0] && asize_w <= rd_size)
                begin
                    state_next = ST_PLACE;
                end
                else
                begin
                    bp_next    = bp_reg + rd_size;
                    steps_next = steps_reg + STEP_W'(1);
                    state_next = ST_SRCH;
                end
            end
            ST_GROW:
            begin
                if ({1'b0, hb_reg} + {1'b0, gsize} > HEAP_W)
                begin
                    stat_next  = STAT_NOMEM;
                    state_next = ST_DONE;
                end
                else
                begin
                    mem_we     = 1'b1;
                    mem_addr   = tidx(hb_reg - 32'd4);
                    mem_wdata  = gsize;
                    bp_next    = hb_reg;
                    sz_next    = gsize;
                    state_next = ST_GROW_W1;
                end
            end
            ST_GROW_W1:
            begin
                mem_we     = 1'b1;
                mem_addr   = tidx(bp_reg + sz_reg - 32'd8);
                mem_wdata  = sz_reg;
                state_next = ST_GROW_W2;
            end
            ST_GROW_W2:
            begin
                mem_we        = 1'b1;
                mem_addr      = tidx(bp_reg + sz_reg - 32'd4);
                mem_wdata     = EPILOGUE;
                hb_next       = hb_reg + sz_reg;
                to_place_next = 1'b1;
                state_next    = ST_MRG0;
            end
            ST_MRG0:
            begin
                mem_addr   = tidx(bp_reg - 32'd4);
                state_next = ST_MRG1;
            end
            ST_MRG1:
            begin
                sz_next    = rd_size;
                mem_addr   = tidx(bp_reg - 32'd8);
                state_next = ST_MRG2;
            end
            ST_MRG2:
            begin
                ptag_next  = mem_rdata;
                mem_addr   = tidx(bp_reg + sz_reg - 32'd4);
                state_next = ST_MRG3;
            end
            ST_MRG3:
            begin
                sz_next = sz_reg + (mem_rdata[0] ? 32'd0 : rd_size)
                          + (ptag_reg[0] ? 32'd0 : psize);
                bp_next  = ptag_reg[0] ? bp_reg : (bp_reg - psize);
                nss_next = ptag_reg[0] ? bp_reg : (bp_reg - psize);
                if (!ptag_reg[0] || !mem_rdata[0])
                begin
                    state_next = ST_MRG_W1;
                end
                else
                begin
                    state_next = to_place_reg ? ST_PLACE : ST_REL_FIN;
                end
            end
            ST_MRG_W1:
            begin
                mem_we     = 1'b1;
                mem_addr   = tidx(bp_reg - 32'd4);
                mem_wdata  = sz_reg;
                state_next = ST_MRG_W2;
            end
            ST_MRG_W2:
            begin
                mem_we     = 1'b1;
                mem_addr   = tidx(bp_reg + sz_reg - 32'd8);
                mem_wdata  = sz_reg;
                state_next = to_place_reg ? ST_PLACE : ST_REL_FIN;
            end
            ST_PLACE:
            begin
                mem_addr   = tidx(bp_reg - 32'd4);
                state_next = ST_PLACE_D;
            end
            ST_PLACE_D:
            begin
                sz_next    = rd_size;
                split_next = (rd_size >= asize_w + MIN_BLOCK);
                mem_we     = 1'b1;
                mem_addr   = tidx(bp_reg - 32'd4);
                mem_wdata  = ((rd_size >= asize_w + MIN_BLOCK) ? asize_w : rd_size) | 32'd1;
                state_next = ST_PL_W1;
            end
            ST_PL_W1:
            begin
                mem_we = 1'b1;
                if (split_reg)
                begin
                    mem_addr   = tidx(bp_reg + asize_w - 32'd8);
                    mem_wdata  = asize_w | 32'd1;
                    state_next = ST_PL_W2;
                end
                else
                begin
                    mem_addr   = tidx(bp_reg + sz_reg - 32'd8);
                    mem_wdata  = sz_reg | 32'd1;
                    nss_next   = bp_reg;
                    res_next   = bp_reg[15:0];
                    state_next = rel_after_reg ? ST_REL_CHK : ST_DONE;
                end
            end
            ST_PL_W2:
            begin
                mem_we     = 1'b1;
                mem_addr   = tidx(bp_reg + asize_w - 32'd4);
                mem_wdata  = sz_reg - asize_w;
                state_next = ST_PL_W3;
            end
            ST_PL_W3:
            begin
                mem_we     = 1'b1;
                mem_addr   = tidx(bp_reg + sz_reg - 32'd8);
                mem_wdata  = sz_reg - asize_w;
                nss_next   = bp_reg;
                res_next   = bp_reg[15:0];
                state_next = rel_after_reg ? ST_REL_CHK : ST_DONE;
            end
            ST_REL_CHK:
            begin
                if (ptr_reg == 16'd0 || ptr_reg[2:0] != 3'd0 || ptr_reg < 16'd16
                    || {16'd0, ptr_reg} >= hb_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    mem_addr   = tidx({16'd0, ptr_reg} - 32'd4);
                    state_next = ST_REL_D;
                end
            end
            ST_REL_D:
            begin
                if (!mem_rdata[0] || rd_size < MIN_BLOCK
                    || {17'd0, ptr_reg} + {1'b0, rd_size} > {1'b0, hb_reg})
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    if (copy_en_reg)
                    begin
                        copy_next = ({16'd0, req_reg} < old_len) ? req_reg : old_len[15:0];
                    end
                    mem_we        = 1'b1;
                    mem_addr      = tidx({16'd0, ptr_reg} - 32'd4);
                    mem_wdata     = rd_size;
                    bp_next       = {16'd0, ptr_reg};
                    sz_next       = rd_size;
                    to_place_next = 1'b0;
                    state_next    = ST_REL_W;
                end
            end
            ST_REL_W:
            begin
                mem_we     = 1'b1;
                mem_addr   = tidx(bp_reg + sz_reg - 32'd8);
                mem_wdata  = sz_reg;
                state_next = ST_MRG0;
            end
            ST_REL_FIN:
            begin
                if (cnt_reg + 16'd1 >= frc_reg)
                begin
                    nss_next = FIRST_BLOCK;
                    cnt_next = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 16'd1;
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next    = 1'b1;
                    ores_next  = res_reg;
                    ostat_next = stat_reg;
                    ocopy_next = copy_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLR;
            clr_reg   <= '0;
            hb_reg    <= HB_RESET;
            nss_reg   <= NSS_RESET;
            cnt_reg   <= '0;
            frc_reg   <= FREE_RESET_DEF;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            hb_reg    <= hb_next;
            nss_reg   <= nss_next;
            cnt_reg   <= cnt_next;
            frc_reg   <= frc_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg       <= ptr_next;
        req_reg       <= req_next;
        asize_reg     <= asize_next;
        bp_reg        <= bp_next;
        sz_reg        <= sz_next;
        ptag_reg      <= ptag_next;
        steps_reg     <= steps_next;
        res_reg       <= res_next;
        stat_reg      <= stat_next;
        copy_reg      <= copy_next;
        rel_after_reg <= rel_after_next;
        copy_en_reg   <= copy_en_next;
        to_place_reg  <= to_place_next;
        split_reg     <= split_next;
        ores_reg      <= ores_next;
        ostat_reg     <= ostat_next;
        ocopy_reg     <= ocopy_next;
    end

endmodule
